>>> hdl/cdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cdq_pkg;
	localparam int DEPTH = 8;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OCC_W = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;

	localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
	localparam logic [1:0] REQ_PUSH_REAR  = 2'd1;
	localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
	localparam logic [1:0] REQ_POP_REAR   = 2'd3;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;
endpackage
`default_nettype wire

>>> hdl/circular_deque.sv
// The result is valid in the respond state, which follows the input transfer and the execute state.
// A new request is taken only after the last result is taken; the controller runs accept, execute and
// respond in turn, and the execute state holds the registered storage read.
// Reset (arst_n low): front/rear indices and count cleared, deque empty, no result pending.
// Entry storage is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module circular_deque (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [1:0]                         req_type,
	input  wire logic signed [cdq_pkg::DATA_W-1:0]  push_value,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [1:0]                              status,
	output logic signed [cdq_pkg::DATA_W-1:0]       pop_value
);
	cdq_pkg::cmd_t cmd;

	cdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	cdq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.req_type   (req_type),
		.push_value (push_value),
		.status     (status),
		.pop_value  (pop_value)
	);
endmodule
`default_nettype wire

>>> hdl/cdq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module cdq_ctrl (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	output cdq_pkg::cmd_t   cmd
);
	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_RESP = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_EXEC;
			S_EXEC: state_d = S_RESP;
			S_RESP: if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_RESP);
	assign cmd.load  = in_ready && in_valid;
	assign cmd.exec  = (state_q == S_EXEC);
endmodule
`default_nettype wire

>>> hdl/cdq_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module cdq_dp (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire cdq_pkg::cmd_t                      cmd,
	input  wire logic [1:0]                         req_type,
	input  wire logic signed [cdq_pkg::DATA_W-1:0]  push_value,
	output logic [1:0]                              status,
	output logic signed [cdq_pkg::DATA_W-1:0]       pop_value
);
	localparam logic [cdq_pkg::IDX_W-1:0] IDX_LAST = cdq_pkg::IDX_W'(cdq_pkg::DEPTH - 1);
	localparam logic [cdq_pkg::OCC_W-1:0] OCC_FULL = cdq_pkg::OCC_W'(cdq_pkg::DEPTH);
	localparam logic [cdq_pkg::OCC_W-1:0] OCC_ONE  = cdq_pkg::OCC_W'(1);

	logic [cdq_pkg::DATA_W-1:0] mem [cdq_pkg::DEPTH];
	logic [cdq_pkg::DATA_W-1:0] rd_q;
	logic [cdq_pkg::DATA_W-1:0] val_q;
	logic [1:0]                 req_q;
	logic [1:0]                 status_q;
	logic                       pop_sel_q;
	logic [cdq_pkg::IDX_W-1:0]  head_q, tail_q, head_d, tail_d;
	logic [cdq_pkg::OCC_W-1:0]  occ_q, occ_d;
	logic [cdq_pkg::IDX_W-1:0]  head_up, head_dn, tail_up, tail_dn;
	logic [cdq_pkg::IDX_W-1:0]  wr_addr, rd_addr;
	logic                       is_push, is_front, full, empty, wr_en, rd_en;
	logic [1:0]                 status_d;

	assign is_push  = (req_q == cdq_pkg::REQ_PUSH_FRONT) || (req_q == cdq_pkg::REQ_PUSH_REAR);
	assign is_front = (req_q == cdq_pkg::REQ_PUSH_FRONT) || (req_q == cdq_pkg::REQ_POP_FRONT);
	assign full     = (occ_q == OCC_FULL);
	assign empty    = (occ_q == '0);

	assign head_up = (head_q == IDX_LAST) ? '0 : head_q + 1'b1;
	assign head_dn = (head_q == '0) ? IDX_LAST : head_q - 1'b1;
	assign tail_up = (tail_q == IDX_LAST) ? '0 : tail_q + 1'b1;
	assign tail_dn = (tail_q == '0) ? IDX_LAST : tail_q - 1'b1;

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		occ_d    = occ_q;
		status_d = cdq_pkg::ST_DONE;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		wr_addr  = '0;
		rd_addr  = is_front ? head_q : tail_q;
		if (is_push) begin
			if (full) begin
				status_d = cdq_pkg::ST_FULL;
			end else begin
				wr_en = 1'b1;
				occ_d = occ_q + 1'b1;
				priority if (empty) begin
					head_d = '0;
					tail_d = '0;
				end else if (is_front) begin
					head_d  = head_dn;
					wr_addr = head_dn;
				end else begin
					tail_d  = tail_up;
					wr_addr = tail_up;
				end
			end
		end else begin
			if (empty) begin
				status_d = cdq_pkg::ST_EMPTY;
			end else begin
				rd_en = 1'b1;
				occ_d = occ_q - 1'b1;
				priority if (occ_q == OCC_ONE) begin
					head_d = '0;
					tail_d = '0;
				end else if (is_front) begin
					head_d = head_up;
				end else begin
					tail_d = tail_dn;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			val_q <= push_value;
		end
		if (cmd.exec) begin
			status_q <= status_d;
		end
		if (cmd.exec && wr_en) begin
			mem[wr_addr] <= val_q;
		end
		if (cmd.exec && rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			occ_q     <= '0;
			pop_sel_q <= 1'b0;
		end else if (cmd.exec) begin
			head_q    <= head_d;
			tail_q    <= tail_d;
			occ_q     <= occ_d;
			pop_sel_q <= rd_en;
		end
	end

	assign status    = status_q;
	assign pop_value = pop_sel_q ? rd_q : '0;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_FULL)
		else $error("occupancy above depth");
	a_empty_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q == '0) |-> (head_q == '0 && tail_q == '0))
		else $error("indices not cleared while empty");
	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && is_push && full) |=> (status_q == cdq_pkg::ST_FULL && $stable(occ_q)))
		else $error("push while full not rejected");
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && !is_push && !empty) |=> (occ_q == $past(occ_q) - 1'b1 && pop_sel_q))
		else $error("pop did not consume an entry");
endmodule
`default_nettype wire
